[rtl/rrva_pkg.sv]
// ----------------------------------------------------------------------------
// rrva_pkg
// Shared constants for the round-robin voice allocator: note codes, field
// widths, event kinds, configuration register indexes and their reset values.
// ----------------------------------------------------------------------------
package rrva_pkg;

	// Field widths fixed by the event format.
	localparam int NOTE_W    = 7;
	localparam int TRK_OUT_W = 4;
	localparam int OCT_W     = 4;
	localparam int TIU_W     = 5;
	localparam int CFG_W     = 5;

	// Note codes.
	localparam logic [NOTE_W-1:0] FREE_NOTE = 7'd120;
	localparam logic [NOTE_W-1:0] TOP_NOTE  = 7'd119;

	// Event kinds carried in tuser.
	localparam logic OP_NOTE_ON  = 1'b0;
	localparam logic OP_NOTE_OFF = 1'b1;

	// Configuration register indexes.
	localparam logic REG_OCTAVE_SHIFT  = 1'b0;
	localparam logic REG_TRACKS_IN_USE = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [OCT_W-1:0] OCTAVE_SHIFT_RST  = 4'd4;
	localparam logic [TIU_W-1:0] TRACKS_IN_USE_RST = 5'd16;

endpackage

[rtl/rrva_track_table.sv]
// ----------------------------------------------------------------------------
// rrva_track_table
// Note held on each track. One read port and one write port; every entry
// resets to the free code.
// ----------------------------------------------------------------------------
module rrva_track_table
	import rrva_pkg::*;
#(
	parameter int TRACKS = 16,
	parameter int TW     = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [TW-1:0]     raddr,
	output logic [NOTE_W-1:0] rdata,
	input  logic              we,
	input  logic [TW-1:0]     waddr,
	input  logic [NOTE_W-1:0] wdata
);

	logic [NOTE_W-1:0] note_q [TRACKS];

	// Write port; reset marks every track free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TRACKS; i++) begin
				note_q[i] <= FREE_NOTE;
			end
		end else if (we) begin
			note_q[waddr] <= wdata;
		end
	end

	// Single read port.
	assign rdata = note_q[raddr];

endmodule

[rtl/round_robin_voice_allocator_top.sv]
// ----------------------------------------------------------------------------
// round_robin_voice_allocator_top
// Turns note-on and note-off key words into per-track note words, with
// round-robin track allocation and voice stealing.
// ----------------------------------------------------------------------------
// Sequence: one input word is transposed, then a release scan runs; a note-on
// goes on to modulo steps giving (last track + 1) mod t, a free-track search
// and, when a note is stolen, a second release scan, then the write; each word
// ends in a flush. t is the active track count. The table is visited one track
// per cycle through its single read port, but the release scan holds while a
// matched word cannot enter the pending slot; input is not ready meanwhile.
// Reset: all tracks free, last track 0, octave shift 4, tracks in use 16.
module round_robin_voice_allocator_top
	import rrva_pkg::*;
#(
	parameter int TRACKS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	// Configuration write port.
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	// Input key words.
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // note [6:0], transpose [7]
	input  logic             s_tuser,   // op
	// Output note words.
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [15:0]      m_tdata,   // track [3:0], note_out [10:4], zero [15:11]
	output logic             m_tlast
);

	localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
	localparam int CW = $clog2(TRACKS + 1);

	// Sequencer states.
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_XPOSE = 3'd1;
	localparam logic [2:0] S_REL   = 3'd2;
	localparam logic [2:0] S_MOD   = 3'd3;
	localparam logic [2:0] S_SRCH  = 3'd4;
	localparam logic [2:0] S_HELD  = 3'd5;
	localparam logic [2:0] S_WRITE = 3'd6;
	localparam logic [2:0] S_FLUSH = 3'd7;

	logic [2:0]           state_q;
	logic [OCT_W-1:0]     octave_q;
	logic [TIU_W-1:0]     tiu_q;
	logic                 op_q;
	logic                 xp_q;
	logic [NOTE_W-1:0]    note_in_q;
	logic [NOTE_W-1:0]    n_q;
	logic [NOTE_W-1:0]    rel_note_q;
	logic                 phase_q;
	logic [TW-1:0]        idx_q;
	logic [TW-1:0]        k_q;
	logic [CW-1:0]        c_q;
	logic [TW-1:0]        last_q;

	logic                 pend_valid_q;
	logic [TRK_OUT_W-1:0] pend_trk_q;
	logic [NOTE_W-1:0]    pend_note_q;
	logic                 out_valid_q;
	logic [TRK_OUT_W-1:0] out_trk_q;
	logic [NOTE_W-1:0]    out_note_q;
	logic                 out_last_q;

	logic [CW-1:0]        act;
	logic [8:0]           xsum;
	logic [NOTE_W-1:0]    xnote;
	logic [TW-1:0]        raddr;
	logic [NOTE_W-1:0]    rdata;
	logic                 tbl_we;
	logic [TW-1:0]        tbl_waddr;
	logic [NOTE_W-1:0]    tbl_wdata;
	logic                 match;
	logic                 rel_end;
	logic [CW-1:0]        c_next;
	logic                 out_free;
	logic                 emit_ok;
	logic                 emit_fire;
	logic [TRK_OUT_W-1:0] emit_trk;
	logic [NOTE_W-1:0]    emit_note;
	logic                 push;
	logic                 push_last;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_q <= OCTAVE_SHIFT_RST;
			tiu_q    <= TRACKS_IN_USE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OCTAVE_SHIFT:  octave_q <= cfg_wdata[OCT_W-1:0];
				REG_TRACKS_IN_USE: tiu_q    <= cfg_wdata[TIU_W-1:0];
				default:           octave_q <= octave_q;
			endcase
		end
	end

	// Active track count, clamped to 1..TRACKS.
	always_comb begin
		if (tiu_q == '0) begin
			act = CW'(1);
		end else if (int'(tiu_q) > TRACKS) begin
			act = CW'(TRACKS);
		end else begin
			act = CW'(tiu_q);
		end
	end

	// Octave transposition: add octave * 12 (as 8x + 4x), clamp to the top note.
	always_comb begin
		xsum  = {2'b00, note_in_q} + {2'b00, octave_q, 3'b000} + {3'b000, octave_q, 2'b00};
		xnote = note_in_q;
		if (note_in_q < FREE_NOTE && xp_q) begin
			xnote = (xsum > {2'b00, TOP_NOTE}) ? TOP_NOTE : xsum[NOTE_W-1:0];
		end
	end

	rrva_track_table #(
		.TRACKS(TRACKS),
		.TW    (TW)
	) u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.raddr (raddr),
		.rdata (rdata),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata)
	);

	// Table address and shared compare results.
	assign raddr   = (state_q == S_REL) ? idx_q : c_q[TW-1:0];
	assign match   = (rdata == rel_note_q) && (rel_note_q != FREE_NOTE);
	assign rel_end = (CW'(idx_q) + CW'(1)) == act;
	assign c_next  = ((c_q + CW'(1)) == act) ? '0 : c_q + CW'(1);

	// A word may enter the pending slot when that slot is empty or can move on to the output.
	assign out_free = !out_valid_q || m_tready;
	assign emit_ok  = !pend_valid_q || out_free;

	// Word produced by the sequencer this cycle and the table write it implies.
	always_comb begin
		emit_fire = 1'b0;
		emit_trk  = TRK_OUT_W'(idx_q);
		emit_note = FREE_NOTE;
		tbl_we    = 1'b0;
		tbl_waddr = idx_q;
		tbl_wdata = FREE_NOTE;
		case (state_q)
			S_REL: begin
				if (match && emit_ok) begin
					emit_fire = 1'b1;
					tbl_we    = 1'b1;
				end
			end
			S_WRITE: begin
				emit_trk  = TRK_OUT_W'(c_q);
				emit_note = n_q;
				tbl_waddr = c_q[TW-1:0];
				tbl_wdata = n_q;
				if (emit_ok) begin
					emit_fire = 1'b1;
					tbl_we    = 1'b1;
				end
			end
			default: begin
				emit_fire = 1'b0;
			end
		endcase
	end

	// Pending word leaves for the output when displaced or at the final flush.
	assign push_last = (state_q == S_FLUSH) && pend_valid_q && out_free;
	assign push      = (emit_fire && pend_valid_q) || push_last;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_XPOSE;
					end
				end
				S_XPOSE: begin
					state_q <= S_REL;
				end
				S_REL: begin
					if ((!match || emit_ok) && rel_end) begin
						if (phase_q) begin
							state_q <= S_WRITE;
						end else if (op_q == OP_NOTE_OFF) begin
							state_q <= S_FLUSH;
						end else begin
							state_q <= S_MOD;
						end
					end
				end
				S_MOD: begin
					if (c_q < act) begin
						state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					if (rdata == FREE_NOTE || (CW'(k_q) + CW'(1)) == act) begin
						state_q <= S_HELD;
					end
				end
				S_HELD: begin
					state_q <= (rdata < FREE_NOTE) ? S_REL : S_WRITE;
				end
				S_WRITE: begin
					if (emit_ok) begin
						last_q  <= c_q[TW-1:0];
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					if (!pend_valid_q || out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Sequencer working registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					note_in_q <= s_tdata[NOTE_W-1:0];
					xp_q      <= s_tdata[7];
					op_q      <= s_tuser;
				end
			end
			S_XPOSE: begin
				n_q        <= xnote;
				rel_note_q <= xnote;
				phase_q    <= 1'b0;
				idx_q      <= '0;
				c_q        <= CW'(last_q) + CW'(1);
			end
			S_REL: begin
				if ((!match || emit_ok) && !rel_end) begin
					idx_q <= idx_q + TW'(1);
				end
			end
			S_MOD: begin
				// Repeated subtraction gives (last track + 1) mod t.
				if (c_q >= act) begin
					c_q <= c_q - act;
				end else begin
					k_q <= '0;
				end
			end
			S_SRCH: begin
				if (rdata != FREE_NOTE) begin
					c_q <= c_next;
					k_q <= k_q + TW'(1);
				end
			end
			S_HELD: begin
				rel_note_q <= rdata;
				phase_q    <= 1'b1;
				idx_q      <= '0;
			end
			default: begin
				phase_q <= phase_q;
			end
		endcase
	end

	// Pending slot: holds the newest word until it is known whether it is last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (emit_fire) begin
			pend_valid_q <= 1'b1;
		end else if (push_last) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			pend_trk_q  <= emit_trk;
			pend_note_q <= emit_note;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (out_valid_q && !m_tready) || push;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_trk_q  <= pend_trk_q;
			out_note_q <= pend_note_q;
			out_last_q <= push_last;
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b00000, out_note_q, out_trk_q};
	assign m_tlast  = out_last_q;

endmodule
